FILE: sv/asa_pkg.sv
// ----------------------------------------------------------------------------
// ADC scan package
// Widths, register indexes, reset values and control types shared by the
// scan, scaling and averaging block.
// ----------------------------------------------------------------------------
package asa_pkg;

    localparam int RAW_W      = 16;
    localparam int CHAN_W     = 3;
    localparam int VAL_W      = 32;
    localparam int WEIGHT_W   = 8;
    localparam int COEFF_W    = 64;
    localparam int COEFF_REGS = 5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OVER   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR  = 3'd7;

    localparam logic [COEFF_W-1:0]  COEFF_RESET  = 64'h0001_0000_0000_0000;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 8'd10;
    localparam logic [VAL_W-1:0]    VAL_MAX      = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0]    VAL_MIN      = 32'h8000_0000;

    localparam int MUL_B_W        = 16;
    localparam int MUL_HI_W       = 34;
    localparam int PROD_W         = 49;
    localparam int NUM_W          = 41;
    localparam int MUL_STEPS      = 16;
    localparam int MUL_HALF_STEPS = 8;
    localparam int DIV_STEPS      = 32;

    typedef struct packed {
        logic start;
        logic half;
    } mul_ctl_t;

    typedef struct packed {
        logic [VAL_W-1:0]    slope;
        logic [VAL_W-1:0]    offset;
        logic [WEIGHT_W-1:0] weight_n;
        logic [WEIGHT_W-1:0] weight_m1;
        logic [VAL_W-1:0]    over_limit;
        logic [VAL_W-1:0]    clear_limit;
    } chan_cfg_t;

endpackage

FILE: sv/asa_in_if.sv
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying one raw conversion result per request.
// ----------------------------------------------------------------------------
interface asa_in_if;
    import asa_pkg::*;

    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_sample;

    modport source (output valid, output raw_sample, input ready);
    modport sink   (input valid, input raw_sample, output ready);
endinterface

FILE: sv/asa_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the scaled value, average and battery status.
// ----------------------------------------------------------------------------
interface asa_out_if;
    import asa_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CHAN_W-1:0]       chan;
    logic signed [VAL_W-1:0] scaled_value;
    logic signed [VAL_W-1:0] avg_value;
    logic                    overvoltage;
    logic                    stop_request;

    modport source (output valid, output chan, output scaled_value, output avg_value,
                    output overvoltage, output stop_request, input ready);
    modport sink   (input valid, input chan, input scaled_value, input avg_value,
                    input overvoltage, input stop_request, output ready);
endinterface

FILE: sv/asa_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Per-channel slope and offset, averaging weight and battery limits, with the
// coefficients of the selected channel presented to the datapath.
// ----------------------------------------------------------------------------
module asa_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [asa_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [asa_pkg::CFG_DATA_W-1:0]   wr_data,
    input  logic [asa_pkg::CHAN_W-1:0]       sel,
    output asa_pkg::chan_cfg_t               cfg
);
    import asa_pkg::*;

    logic [COEFF_W-1:0]  coeff_reg [COEFF_REGS];
    logic [WEIGHT_W-1:0] weight_reg;
    logic [VAL_W-1:0]    over_reg;
    logic [VAL_W-1:0]    clear_reg;
    logic [WEIGHT_W-1:0] weight_n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COEFF_REGS; i++)
            begin
                coeff_reg[i] <= COEFF_RESET;
            end
            weight_reg <= WEIGHT_RESET;
            over_reg   <= VAL_MAX;
            clear_reg  <= VAL_MAX;
        end
        else if (wr_en)
        begin
            priority if (wr_index < CFG_IDX_W'(COEFF_REGS))
            begin
                coeff_reg[wr_index] <= wr_data[COEFF_W-1:0];
            end
            else if (wr_index == REG_WEIGHT)
            begin
                weight_reg <= wr_data[WEIGHT_W-1:0];
            end
            else if (wr_index == REG_OVER)
            begin
                over_reg <= wr_data[VAL_W-1:0];
            end
            else if (wr_index == REG_CLEAR)
            begin
                clear_reg <= wr_data[VAL_W-1:0];
            end
        end
    end

    assign weight_n = (weight_reg == '0) ? WEIGHT_W'(1) : weight_reg;

    assign cfg.slope       = coeff_reg[sel][COEFF_W-1:VAL_W];
    assign cfg.offset      = coeff_reg[sel][VAL_W-1:0];
    assign cfg.weight_n    = weight_n;
    assign cfg.weight_m1   = weight_n - WEIGHT_W'(1);
    assign cfg.over_limit  = over_reg;
    assign cfg.clear_limit = clear_reg;

endmodule

FILE: sv/asa_mul.sv
// ----------------------------------------------------------------------------
// Serial multiply-accumulate
// Computes a * b + c for signed a and c and unsigned b, one multiplier bit
// per cycle, over sixteen bits or over the low eight bits in half mode.
// ----------------------------------------------------------------------------
module asa_mul (
    input  logic                               clk,
    input  logic                               rst_n,
    input  asa_pkg::mul_ctl_t                  ctl,
    input  logic [asa_pkg::VAL_W-1:0]          a,
    input  logic [asa_pkg::MUL_B_W-1:0]        b,
    input  logic [asa_pkg::VAL_W-1:0]          c,
    output logic signed [asa_pkg::PROD_W-1:0]  prod,
    output logic                               done
);
    import asa_pkg::*;

    localparam int CNT_W = $clog2(MUL_STEPS + 1);

    logic                       busy_reg;
    logic                       done_reg;
    logic                       half_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [VAL_W-1:0]           a_reg;
    logic signed [MUL_HI_W-1:0] hi_reg;
    logic [MUL_B_W-1:0]         lo_reg;
    logic signed [MUL_HI_W-1:0] addend;
    logic signed [MUL_HI_W-1:0] sum;

    assign addend = lo_reg[0] ? {{(MUL_HI_W-VAL_W){a_reg[VAL_W-1]}}, a_reg} : '0;
    assign sum    = hi_reg + addend;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctl.half ? CNT_W'(MUL_HALF_STEPS) : CNT_W'(MUL_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            half_reg <= ctl.half;
            a_reg    <= a;
            hi_reg   <= {{(MUL_HI_W-VAL_W){c[VAL_W-1]}}, c};
            lo_reg   <= b;
        end
        else if (busy_reg)
        begin
            hi_reg <= {sum[MUL_HI_W-1], sum[MUL_HI_W-1:1]};
            lo_reg <= {sum[0], lo_reg[MUL_B_W-1:1]};
        end
    end

    assign prod = half_reg
                ? {{(PROD_W-NUM_W){hi_reg[MUL_HI_W-2]}}, hi_reg[MUL_HI_W-2:0],
                   lo_reg[MUL_B_W-1:MUL_HALF_STEPS]}
                : {hi_reg[MUL_HI_W-2:0], lo_reg};
    assign done = done_reg;

endmodule

FILE: sv/asa_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Divides a signed numerator by an unsigned 8-bit weight, one quotient bit
// per cycle, truncating toward zero and saturating to 32 bits.
// ----------------------------------------------------------------------------
module asa_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [asa_pkg::NUM_W-1:0]         num,
    input  logic [asa_pkg::WEIGHT_W-1:0]      den,
    output logic signed [asa_pkg::VAL_W-1:0]  quot,
    output logic                              done
);
    import asa_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  neg_reg;
    logic [WEIGHT_W-1:0]   den_reg;
    logic [WEIGHT_W-1:0]   rem_reg;
    logic [VAL_W-1:0]      q_reg;
    logic [NUM_W-1:0]      mag;
    logic [WEIGHT_W:0]     trial;
    logic                  fits;
    logic [WEIGHT_W:0]     diff;
    logic [VAL_W:0]        signed_q;

    assign mag   = num[NUM_W-1] ? (~num + NUM_W'(1)) : num;
    assign trial = {rem_reg, q_reg[VAL_W-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[NUM_W-1];
            den_reg <= den;
            rem_reg <= mag[VAL_W+WEIGHT_W-1:VAL_W];
            q_reg   <= mag[VAL_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[WEIGHT_W-1:0] : trial[WEIGHT_W-1:0];
            q_reg   <= {q_reg[VAL_W-2:0], fits};
        end
    end

    assign signed_q = neg_reg ? (~{1'b0, q_reg} + (VAL_W+1)'(1)) : {1'b0, q_reg};

    always_comb
    begin
        if (signed_q[VAL_W] != signed_q[VAL_W-1])
        begin
            quot = signed_q[VAL_W] ? VAL_MIN : VAL_MAX;
        end
        else
        begin
            quot = signed_q[VAL_W-1:0];
        end
    end

    assign done = done_reg;

endmodule

FILE: sv/adc_scan_scale_average.sv
// ----------------------------------------------------------------------------
// ADC scan with scaling and averaging
// Credits each conversion to the next channel of a round-robin scan, scales it
// with the channel's slope and offset and updates the channel's running mean.
// The shared bit-serial multiplier (16 plus 8 steps) and the 32-step serial
// divider work on one sample at a time: a new sample request is taken only
// after the last result has been loaded into the result register.
// Reset clears the scan index, all averages and the overvoltage flag, and
// returns the configuration registers to their defaults at once.
// ----------------------------------------------------------------------------
module adc_scan_scale_average #(
    parameter int NUM_CHANNELS = 5,
    parameter int VBAT_CHANNEL = 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [asa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [asa_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    asa_in_if.sink                          sample,
    asa_out_if.source                       result
);
    import asa_pkg::*;

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_SAT,
        ST_AVG,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t                   state_reg;
    logic [CHAN_W-1:0]        scan_reg;
    logic                     ov_reg;
    logic [VAL_W-1:0]         avg_reg [NUM_CHANNELS];
    logic [VAL_W-1:0]         scaled_reg;
    logic [VAL_W-1:0]         avg_new_reg;
    logic                     out_valid_reg;
    logic [CHAN_W-1:0]        out_chan_reg;
    logic [VAL_W-1:0]         out_scaled_reg;
    logic [VAL_W-1:0]         out_avg_reg;
    logic                     out_ov_reg;
    logic                     out_stop_reg;

    chan_cfg_t                cfg;
    mul_ctl_t                 mul_ctl;
    logic [VAL_W-1:0]         mul_a;
    logic [MUL_B_W-1:0]       mul_b;
    logic [VAL_W-1:0]         mul_c;
    logic signed [PROD_W-1:0] prod;
    logic                     mul_done;
    logic                     div_start;
    logic signed [VAL_W-1:0]  quot;
    logic                     div_done;
    logic [VAL_W-1:0]         scaled_sat;
    logic                     accept;
    logic                     is_vbat;
    logic                     above;
    logic                     below;
    logic [CHAN_W-1:0]        scan_next;
    logic [IDX_W-1:0]         idx;

    asa_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_wr_en),
        .wr_index (cfg_index),
        .wr_data  (cfg_wdata),
        .sel      (scan_reg),
        .cfg      (cfg)
    );

    asa_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mul_ctl),
        .a     (mul_a),
        .b     (mul_b),
        .c     (mul_c),
        .prod  (prod),
        .done  (mul_done)
    );

    asa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod[NUM_W-1:0]),
        .den   (cfg.weight_n),
        .quot  (quot),
        .done  (div_done)
    );

    assign idx    = scan_reg[IDX_W-1:0];
    assign accept = sample.valid && sample.ready;

    assign mul_ctl.start = accept || (state_reg == ST_SAT);
    assign mul_ctl.half  = (state_reg == ST_SAT);
    assign mul_a = (state_reg == ST_SAT) ? avg_reg[idx] : cfg.slope;
    assign mul_b = (state_reg == ST_SAT) ? {{(MUL_B_W-WEIGHT_W){1'b0}}, cfg.weight_m1}
                                         : sample.raw_sample;
    assign mul_c = (state_reg == ST_SAT) ? scaled_reg : cfg.offset;

    assign div_start = (state_reg == ST_AVG) && mul_done;

    always_comb
    begin
        if ((&prod[PROD_W-1:VAL_W-1]) || !(|prod[PROD_W-1:VAL_W-1]))
        begin
            scaled_sat = prod[VAL_W-1:0];
        end
        else
        begin
            scaled_sat = prod[PROD_W-1] ? VAL_MIN : VAL_MAX;
        end
    end

    assign is_vbat   = (scan_reg == CHAN_W'(VBAT_CHANNEL));
    assign above     = $signed(avg_new_reg) > $signed(cfg.over_limit);
    assign below     = $signed(avg_new_reg) < $signed(cfg.clear_limit);
    assign scan_next = (scan_reg == CHAN_W'(NUM_CHANNELS - 1)) ? '0
                                                               : scan_reg + CHAN_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_reg      <= '0;
            ov_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                avg_reg[i] <= '0;
            end
        end
        else
        begin
            if (result.ready && (state_reg != ST_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_SCALE;
                    end
                end
                ST_SCALE:
                begin
                    if (mul_done)
                    begin
                        scaled_reg <= scaled_sat;
                        state_reg  <= ST_SAT;
                    end
                end
                ST_SAT:
                begin
                    state_reg <= ST_AVG;
                end
                ST_AVG:
                begin
                    if (mul_done)
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        avg_new_reg <= quot;
                        state_reg   <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_chan_reg   <= scan_reg;
                        out_scaled_reg <= scaled_reg;
                        out_avg_reg    <= avg_new_reg;
                        out_stop_reg   <= is_vbat && above;
                        priority if (is_vbat && above)
                        begin
                            ov_reg     <= 1'b1;
                            out_ov_reg <= 1'b1;
                        end
                        else if (is_vbat && below)
                        begin
                            ov_reg     <= 1'b0;
                            out_ov_reg <= 1'b0;
                        end
                        else
                        begin
                            out_ov_reg <= ov_reg;
                        end
                        avg_reg[idx] <= avg_new_reg;
                        scan_reg     <= scan_next;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign sample.ready        = (state_reg == ST_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.chan         = out_chan_reg;
    assign result.scaled_value = out_scaled_reg;
    assign result.avg_value    = out_avg_reg;
    assign result.overvoltage  = out_ov_reg;
    assign result.stop_request = out_stop_reg;

endmodule

FILE: sv/asa_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Watches the sample and result channels of the scan block for sequencing,
// channel range, stable results under stall and battery status consistency.
// ----------------------------------------------------------------------------
module asa_checker #(
    parameter int NUM_CHANNELS = 5,
    parameter int VBAT_CHANNEL = 1
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [asa_pkg::CHAN_W-1:0]   chan,
    input logic [asa_pkg::VAL_W-1:0]    scaled_value,
    input logic [asa_pkg::VAL_W-1:0]    avg_value,
    input logic                         overvoltage,
    input logic                         stop_request
);
    import asa_pkg::*;

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("A second sample request was taken while one was in work.");

    a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (chan < CHAN_W'(NUM_CHANNELS)))
        else $error("Result names a channel outside the scan.");

    a_stop_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stop_request) |-> overvoltage)
        else $error("Stop request without the overvoltage flag.");

    a_stop_on_vbat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stop_request) |-> (chan == CHAN_W'(VBAT_CHANNEL)))
        else $error("Stop request on a channel other than the battery.");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(chan)
            && $stable(scaled_value) && $stable(avg_value)
            && $stable(overvoltage) && $stable(stop_request)))
        else $error("Stalled result changed.");

endmodule

bind adc_scan_scale_average asa_checker #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .VBAT_CHANNEL (VBAT_CHANNEL)
) u_asa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (sample.valid),
    .in_ready     (sample.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .chan         (result.chan),
    .scaled_value (result.scaled_value),
    .avg_value    (result.avg_value),
    .overvoltage  (result.overvoltage),
    .stop_request (result.stop_request)
);

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// ADC scan, scale and average testbench
// Feeds raw conversion results through the sample channel under several
// coefficient, weight and limit settings, predicts the channel, scaled value,
// running average and battery status of every request, and checks each result
// in order while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import asa_pkg::*;

    localparam int NUM_CHANNELS  = 5;
    localparam int VBAT_CHANNEL  = 1;
    localparam int NUM_REGS      = 8;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS   = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 70;
    localparam int STALL_LIMIT   = 2000;

    typedef struct packed {
        logic [CHAN_W-1:0]       chan;
        logic signed [VAL_W-1:0] scaled;
        logic signed [VAL_W-1:0] avg;
        logic                    overvoltage;
        logic                    stop_request;
    } scan_result_t;

    function automatic logic signed [VAL_W-1:0] clamp_val(input longint v);
        if (v > longint'($signed(VAL_MAX)))
            return VAL_MAX;
        if (v < longint'($signed(VAL_MIN)))
            return VAL_MIN;
        return v[VAL_W-1:0];
    endfunction

    function automatic logic signed [VAL_W-1:0] scale_sample(
        input logic [COEFF_W-1:0] coeff,
        input logic [RAW_W-1:0]   raw
    );
        longint slope;
        longint offset;
        slope  = longint'($signed(coeff[COEFF_W-1:VAL_W]));
        offset = longint'($signed(coeff[VAL_W-1:0]));
        return clamp_val(slope * longint'({48'd0, raw}) + offset);
    endfunction

    class scan_scoreboard;
        logic [COEFF_W-1:0]      coeffs[COEFF_REGS];
        logic [WEIGHT_W-1:0]     weight;
        logic signed [VAL_W-1:0] over_limit;
        logic signed [VAL_W-1:0] clear_limit;
        int unsigned             scan_pos;
        logic signed [VAL_W-1:0] chan_mean[COEFF_REGS];
        logic                    ov_flag;
        scan_result_t            awaited[$];
        int unsigned             errors;

        function new();
            for (int i = 0; i < COEFF_REGS; i++)
            begin
                coeffs[i]    = COEFF_RESET;
                chan_mean[i] = '0;
            end
            weight      = WEIGHT_RESET;
            over_limit  = VAL_MAX;
            clear_limit = VAL_MAX;
            scan_pos    = 0;
            ov_flag     = 1'b0;
            errors      = 0;
        endfunction

        function void note_config(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_WEIGHT: weight      = data[WEIGHT_W-1:0];
                REG_OVER:   over_limit  = data[VAL_W-1:0];
                REG_CLEAR:  clear_limit = data[VAL_W-1:0];
                default:    coeffs[idx] = data;
            endcase
        endfunction

        function void add_sample(input logic [RAW_W-1:0] raw);
            scan_result_t r;
            longint       n;
            longint       sum;
            int unsigned  ch;
            ch = scan_pos;
            n = (weight == '0) ? 64'sd1 : longint'({56'd0, weight});
            r.chan = CHAN_W'(ch);
            r.scaled = scale_sample(coeffs[ch], raw);
            sum = longint'(chan_mean[ch]) * (n - 1) + longint'(r.scaled);
            r.avg = clamp_val(sum / n);
            chan_mean[ch] = r.avg;
            r.stop_request = 1'b0;
            if (ch == VBAT_CHANNEL)
            begin
                if (r.avg > over_limit)
                begin
                    ov_flag = 1'b1;
                    r.stop_request = 1'b1;
                end
                else if (r.avg < clear_limit)
                    ov_flag = 1'b0;
            end
            r.overvoltage = ov_flag;
            scan_pos = (ch + 1 >= NUM_CHANNELS) ? 0 : ch + 1;
            awaited.push_back(r);
        endfunction

        function void check_result(input scan_result_t got);
            scan_result_t want;
            if (awaited.size() == 0)
            begin
                $error("result on channel %0d with no request outstanding", got.chan);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.chan !== want.chan)
            begin
                $error("chan: expected %0d, got %0d", want.chan, got.chan);
                errors++;
            end
            if (got.scaled !== want.scaled)
            begin
                $error("scaled_value: expected %0d, got %0d", want.scaled, got.scaled);
                errors++;
            end
            if (got.avg !== want.avg)
            begin
                $error("avg_value: expected %0d, got %0d", want.avg, got.avg);
                errors++;
            end
            if (got.overvoltage !== want.overvoltage)
            begin
                $error("overvoltage: expected %0b, got %0b",
                       want.overvoltage, got.overvoltage);
                errors++;
            end
            if (got.stop_request !== want.stop_request)
            begin
                $error("stop_request: expected %0b, got %0b",
                       want.stop_request, got.stop_request);
                errors++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    asa_in_if  sample_if();
    asa_out_if result_if();

    scan_scoreboard        board = new();
    logic [CFG_DATA_W-1:0] reg_vals[NUM_REGS];
    bit                    tx_idle_on = 1'b1;
    bit                    rx_idle_on = 1'b1;
    bit                    long_hold_req = 1'b0;

    always #2 clk = ~clk;

    adc_scan_scale_average #(
        .NUM_CHANNELS(NUM_CHANNELS),
        .VBAT_CHANNEL(VBAT_CHANNEL)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .sample    (sample_if),
        .result    (result_if)
    );

    function automatic logic [RAW_W-1:0] random_raw();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return RAW_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_coeff();
        logic [VAL_W-1:0] slope;
        logic [VAL_W-1:0] offset;
        case ($urandom_range(0, 3))
            0:
            begin
                slope  = $urandom;
                offset = $urandom;
            end
            1:
            begin
                slope  = ($urandom_range(0, 2) == 0) ? '0 :
                         ($urandom_range(0, 1) ? VAL_MAX : VAL_MIN);
                offset = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
            end
            default:
            begin
                slope  = $urandom_range(0, 32'h0002_0000);
                if ($urandom_range(0, 1))
                    slope = -slope;
                offset = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            end
        endcase
        return {slope, offset};
    endfunction

    function automatic void pick_settings(input int phase);
        logic signed [VAL_W-1:0] level_hi;
        logic signed [VAL_W-1:0] level_lo;
        logic signed [VAL_W-1:0] level_tmp;
        logic [WEIGHT_W-1:0]     weight;
        for (int i = 0; i < COEFF_REGS; i++)
            reg_vals[i] = random_coeff();
        level_hi = scale_sample(reg_vals[VBAT_CHANNEL], random_raw());
        level_lo = scale_sample(reg_vals[VBAT_CHANNEL], random_raw());
        if (level_hi < level_lo)
        begin
            level_tmp = level_hi;
            level_hi  = level_lo;
            level_lo  = level_tmp;
        end
        if ($urandom_range(0, 7) == 0)
        begin
            level_tmp = level_hi;
            level_hi  = level_lo;
            level_lo  = level_tmp;
        end
        case ($urandom_range(0, 5))
            0:       weight = '0;
            1:       weight = 8'd1;
            2:       weight = 8'd2;
            3:       weight = 8'd4;
            4:       weight = '1;
            default: weight = WEIGHT_W'($urandom_range(1, 255));
        endcase
        if (phase == 0)
        begin
            weight   = '1;
            level_hi = VAL_MIN;
            level_lo = VAL_MIN;
        end
        else if (phase == 1)
        begin
            weight   = 8'd1;
            level_hi = VAL_MAX;
            level_lo = VAL_MAX;
        end
        reg_vals[REG_WEIGHT] = {56'd0, weight};
        reg_vals[REG_OVER]   = {32'd0, level_hi};
        reg_vals[REG_CLEAR]  = {32'd0, level_lo};
    endfunction

    task automatic apply_settings();
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_wdata <= reg_vals[i];
            @(posedge clk);
            board.note_config(CFG_IDX_W'(i), reg_vals[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_sample(input logic [RAW_W-1:0] raw);
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            sample_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        sample_if.valid      <= 1'b1;
        sample_if.raw_sample <= raw;
        do
            @(posedge clk);
        while (!sample_if.ready);
        board.add_sample(raw);
    endtask

    task automatic wait_all_results();
        sample_if.valid <= 1'b0;
        while (board.awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : result_sink
        scan_result_t got;
        int unsigned  stall_cnt;
        stall_cnt = 0;
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_if.valid && result_if.ready)
            begin
                got.chan         = result_if.chan;
                got.scaled       = result_if.scaled_value;
                got.avg          = result_if.avg_value;
                got.overvoltage  = result_if.overvoltage;
                got.stop_request = result_if.stop_request;
                board.check_result(got);
            end
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_cnt = HOLD_CYCLES;
            end
            else if (stall_cnt == 0 && rx_idle_on && $urandom_range(0, 5) == 0)
                stall_cnt = $urandom_range(1, 6);
            if (stall_cnt > 0)
            begin
                result_if.ready <= 1'b0;
                stall_cnt--;
            end
            else
                result_if.ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("adc_scan_scale_average test failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [RAW_W-1:0] reset_round[5];
        logic [RAW_W-1:0] corner_rounds[15];
        reset_round   = '{16'd0, 16'hFFFF, 16'h5555, 16'hAAAA, 16'd1};
        corner_rounds = '{
            16'hFFFF, 16'd200, 16'hFFFF, 16'hFFFF, 16'd0,
            16'd0,    16'd75,  16'd1,    16'h8000, 16'hFFFF,
            16'h7FFF, 16'd10,  16'hAAAA, 16'h5555, 16'd1
        };
        rst_n                <= 1'b0;
        cfg_wr_en            <= 1'b0;
        cfg_index            <= '0;
        cfg_wdata            <= '0;
        sample_if.valid      <= 1'b0;
        sample_if.raw_sample <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: unity slope, weight ten, limits that never trip.
        foreach (reset_round[i])
            send_sample(reset_round[i]);
        wait_all_results();

        // Saturating coefficients, weight zero, and a battery sequence that
        // trips the limit, holds between the limits, then clears.
        reg_vals[0]            = {VAL_MAX, VAL_MAX};
        reg_vals[VBAT_CHANNEL] = {32'h0001_0000, 32'h0000_0000};
        reg_vals[2]            = {VAL_MIN, VAL_MIN};
        reg_vals[3]            = {32'hFFFF_0000, 32'h1234_5678};
        reg_vals[4]            = {32'h0000_0000, VAL_MIN};
        reg_vals[REG_WEIGHT]   = '0;
        reg_vals[REG_OVER]     = {32'd0, 32'h0064_0000};
        reg_vals[REG_CLEAR]    = {32'd0, 32'h0032_0000};
        apply_settings();
        foreach (corner_rounds[i])
            send_sample(corner_rounds[i]);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_all_results();
            pick_settings(phase);
            apply_settings();
            tx_idle_on = (phase != RANDOM_PHASES - 1);
            rx_idle_on = (phase != RANDOM_PHASES - 1);
            for (int item = 0; item < PHASE_ITEMS; item++)
            begin
                if (phase != RANDOM_PHASES - 1 && item % 25 == 0)
                begin
                    tx_idle_on = ($urandom_range(0, 2) != 0);
                    rx_idle_on = ($urandom_range(0, 2) != 0);
                end
                if (phase == 2 && item == 10)
                    long_hold_req = 1'b1;
                if (phase == 4 && item == 50)
                    wait_all_results();
                send_sample(random_raw());
            end
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("adc_scan_scale_average test passed");
        else
            $display("adc_scan_scale_average test failed");
        $finish;
    end

endmodule

FILE: filelist.f
sv/asa_pkg.sv
sv/asa_in_if.sv
sv/asa_out_if.sv
sv/asa_regs.sv
sv/asa_mul.sv
sv/asa_div.sv
sv/adc_scan_scale_average.sv
sv/asa_checker.sv
tb/testbench.sv
